@@ rtl/core/afcse_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afcse_pkg
// shared types, codes and constants of the adc frame sample extractor
// ----------------------------------------------------------------------------
package afcse_pkg;

    localparam int MAX_CHANNELS = 4;

    // count width covers any channel count up to eight
    localparam int CNT_W = 4;
    localparam int POS_W = 5;
    localparam int SAMPLE_W = 24;
    localparam int CRC_W = 16;
    localparam int WORD_W = 32;
    localparam int OVF_W = 16;
    localparam int B2B_W = 2;
    localparam int KIND_W = 2;

    localparam logic [CRC_W-1:0] CRC_START = 16'hFFFF;
    localparam logic [OVF_W-1:0] OVF_MAX = 16'hFFFF;
    localparam logic [B2B_W-1:0] B2B_MAX = 2'd2;
    localparam logic [CNT_W-1:0] CNT_MIN = 4'd2;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CHANNELS);

    // request codes
    localparam logic FUNC_BYTE = 1'b0;
    localparam logic FUNC_RESTART = 1'b1;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CRC_ERR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RESET_ERR = 2'd2;

    // register indexes
    localparam logic REG_CHANNEL_SELECT = 1'b0;
    localparam logic REG_CHANNEL_COUNT = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] rx_byte;
        logic       ready_after_frame;
    } item_t;

    typedef struct packed {
        logic [KIND_W-1:0] result_kind;
        logic [WORD_W-1:0] packed_word;
        logic [B2B_W-1:0]  back_to_back_count;
        logic [OVF_W-1:0]  overflow_count;
    } result_t;

endpackage

@@ rtl/core/adc_frame_crc_sample_extract.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_frame_crc_sample_extract
// crc-checked adc frame receiver giving one sample or error word per frame
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// s_axis    in         s_tvalid / s_tready    tuser func, tdata byte + ready
// m_axis    out        m_tvalid / m_tready    tuser kind, tdata word + counts
// apb       in         psel / penable / pready  two config registers
//
// one request per cycle unless m_tready stalls: input register, one pass
// of crc and frame logic, result register. the input register holds its
// request while the result register is full and not taken; s_tready
// follows m_tready through that path. reset clears the frame state,
// counters and config to their defaults.
// ----------------------------------------------------------------------------
module adc_frame_crc_sample_extract
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // rx_byte[7:0], ready_after_frame[8], zero pad
    input  logic        s_tuser,   // func[0]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // packed_word[31:0], back_to_back_count[33:32],
                                   // overflow_count[49:34], zero pad
    output logic [1:0]  m_tuser,   // result_kind[1:0]

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                 in_valid_reg, in_valid_next;
    afcse_pkg::item_t     in_item_reg;
    logic                 out_valid_reg, out_valid_next;
    afcse_pkg::result_t   out_res_reg;
    logic [1:0]           sel_reg;
    logic [2:0]           cnt_reg;

    logic                 out_free;
    logic                 go;
    logic                 res_valid;
    afcse_pkg::result_t   res;
    logic                 cfg_write;
    logic                 cfg_index;

    assign out_free = !out_valid_reg || m_tready;
    assign go       = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || go;

    assign in_valid_next  = s_tready ? s_tvalid : in_valid_reg;
    assign out_valid_next = res_valid ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    afcse_frame u_frame
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .go             (go),
        .item           (in_item_reg),
        .channel_select (sel_reg),
        .channel_count  (cnt_reg),
        .res_valid      (res_valid),
        .res            (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_item_reg.func              <= s_tuser;
            in_item_reg.rx_byte           <= s_tdata[7:0];
            in_item_reg.ready_after_frame <= s_tdata[8];
        end
        if (res_valid)
            out_res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.result_kind;
    assign m_tdata  = {6'b000000, out_res_reg.overflow_count,
                       out_res_reg.back_to_back_count, out_res_reg.packed_word};

    // config registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_index = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg <= 2'd0;
            cnt_reg <= 3'd4;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                afcse_pkg::REG_CHANNEL_SELECT: sel_reg <= pwdata[1:0];
                afcse_pkg::REG_CHANNEL_COUNT:  cnt_reg <= pwdata[2:0];
                default:                       sel_reg <= sel_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            afcse_pkg::REG_CHANNEL_SELECT: prdata = {30'd0, sel_reg};
            afcse_pkg::REG_CHANNEL_COUNT:  prdata = {29'd0, cnt_reg};
            default:                       prdata = '0;
        endcase
    end

endmodule

@@ rtl/core/afcse_crc.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afcse_crc
// one-byte update of a crc-16 with polynomial 0x1021, msb first
// ----------------------------------------------------------------------------
module afcse_crc
(
    input  logic [afcse_pkg::CRC_W-1:0] crc,
    input  logic [7:0]                  data,
    output logic [afcse_pkg::CRC_W-1:0] crc_next
);

    logic [7:0] x0;
    logic [7:0] x;

    assign x0 = crc[15:8] ^ data;
    assign x  = x0 ^ {4'h0, x0[7:4]};

    assign crc_next = {crc[7:0], 8'h00}
                    ^ {x[3:0], 12'h000}
                    ^ {3'b000, x, 5'b00000}
                    ^ {8'h00, x};

endmodule

@@ rtl/core/afcse_frame.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afcse_frame
// frame position, crc check, sample capture, reset latch and read counters
// ----------------------------------------------------------------------------
module afcse_frame
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        go,
    input  afcse_pkg::item_t            item,
    input  logic [1:0]                  channel_select,
    input  logic [2:0]                  channel_count,
    output logic                        res_valid,
    output afcse_pkg::result_t          res
);

    logic [afcse_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic [afcse_pkg::CRC_W-1:0]    crc_reg, crc_next;
    logic [afcse_pkg::SAMPLE_W-1:0] sample_reg, sample_next;
    logic [afcse_pkg::CRC_W-1:0]    rx_crc_reg, rx_crc_next;
    logic                           status_rst_reg, status_rst_next;
    logic                           latch_reg, latch_next;
    logic [afcse_pkg::B2B_W-1:0]    b2b_reg, b2b_next;
    logic [afcse_pkg::OVF_W-1:0]    ovf_reg, ovf_next;

    logic [afcse_pkg::CNT_W-1:0]    count_raw;
    logic [afcse_pkg::CNT_W-1:0]    count_eff;
    logic [afcse_pkg::POS_W-1:0]    cnt_plus2;
    logic [afcse_pkg::POS_W-1:0]    frame_len;
    logic [afcse_pkg::POS_W-1:0]    sel_plus1;
    logic [afcse_pkg::POS_W-1:0]    lo;
    logic [afcse_pkg::CRC_W-1:0]    crc_fed;
    logic                           is_last;
    logic                           capture;
    logic                           latch_now;

    afcse_crc u_crc
    (
        .crc      (crc_reg),
        .data     (item.rx_byte),
        .crc_next (crc_fed)
    );

    assign count_raw = afcse_pkg::CNT_W'(channel_count);

    always_comb
    begin
        priority if (count_raw < afcse_pkg::CNT_MIN)
            count_eff = afcse_pkg::CNT_MIN;
        else if (count_raw > afcse_pkg::CNT_MAX)
            count_eff = afcse_pkg::CNT_MAX;
        else
            count_eff = count_raw;
    end

    assign cnt_plus2 = afcse_pkg::POS_W'(count_eff) + afcse_pkg::POS_W'(2);
    assign frame_len = (cnt_plus2 << 1) + cnt_plus2;
    assign sel_plus1 = afcse_pkg::POS_W'(channel_select) + afcse_pkg::POS_W'(1);
    assign lo        = (sel_plus1 << 1) + sel_plus1;
    assign is_last   = (pos_reg >= frame_len - afcse_pkg::POS_W'(1));
    assign capture   = (afcse_pkg::CNT_W'(channel_select) < count_eff)
                     && (pos_reg >= lo) && (pos_reg < lo + afcse_pkg::POS_W'(3));
    assign latch_now = latch_reg || status_rst_reg;

    assign res_valid = go && (item.func == afcse_pkg::FUNC_BYTE) && is_last;

    always_comb
    begin
        pos_next        = pos_reg;
        crc_next        = crc_reg;
        sample_next     = sample_reg;
        rx_crc_next     = rx_crc_reg;
        status_rst_next = status_rst_reg;
        latch_next      = latch_reg;
        b2b_next        = b2b_reg;
        ovf_next        = ovf_reg;

        res.result_kind        = afcse_pkg::KIND_SAMPLE;
        res.packed_word        = {{(afcse_pkg::WORD_W - afcse_pkg::SAMPLE_W)
                                   {sample_reg[afcse_pkg::SAMPLE_W-1]}}, sample_reg};
        res.back_to_back_count = b2b_reg;
        res.overflow_count     = ovf_reg;

        if (item.func == afcse_pkg::FUNC_RESTART)
        begin
            pos_next        = '0;
            crc_next        = afcse_pkg::CRC_START;
            sample_next     = '0;
            rx_crc_next     = '0;
            status_rst_next = 1'b0;
            latch_next      = 1'b0;
            b2b_next        = '0;
            ovf_next        = '0;
        end
        else if (!is_last)
        begin
            if (pos_reg == '0)
                status_rst_next = item.rx_byte[2];
            priority if (pos_reg < frame_len - afcse_pkg::POS_W'(3))
            begin
                crc_next = crc_fed;
                if (capture)
                    sample_next = {sample_reg[15:0], item.rx_byte};
            end
            else if (pos_reg == frame_len - afcse_pkg::POS_W'(3))
                rx_crc_next = {item.rx_byte, rx_crc_reg[7:0]};
            else
                rx_crc_next = {rx_crc_reg[15:8], item.rx_byte};
            pos_next = pos_reg + afcse_pkg::POS_W'(1);
        end
        else
        begin
            priority if (crc_reg != rx_crc_reg)
            begin
                res.result_kind = afcse_pkg::KIND_CRC_ERR;
                res.packed_word = {6'd0, afcse_pkg::KIND_CRC_ERR, 24'h000000};
            end
            else if (latch_now)
            begin
                latch_next      = 1'b1;
                res.result_kind = afcse_pkg::KIND_RESET_ERR;
                res.packed_word = {6'd0, afcse_pkg::KIND_RESET_ERR, 24'h000000};
            end
            else
            begin
                priority if (!item.ready_after_frame)
                    b2b_next = '0;
                else if (b2b_reg >= afcse_pkg::B2B_MAX)
                begin
                    b2b_next = afcse_pkg::B2B_MAX;
                    if (ovf_reg != afcse_pkg::OVF_MAX)
                        ovf_next = ovf_reg + afcse_pkg::OVF_W'(1);
                end
                else
                    b2b_next = b2b_reg + afcse_pkg::B2B_W'(1);
            end
            res.back_to_back_count = b2b_next;
            res.overflow_count     = ovf_next;
            // frame done, start over
            pos_next        = '0;
            crc_next        = afcse_pkg::CRC_START;
            sample_next     = '0;
            rx_crc_next     = '0;
            status_rst_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            crc_reg        <= afcse_pkg::CRC_START;
            sample_reg     <= '0;
            rx_crc_reg     <= '0;
            status_rst_reg <= 1'b0;
            latch_reg      <= 1'b0;
            b2b_reg        <= '0;
            ovf_reg        <= '0;
        end
        else if (go)
        begin
            pos_reg        <= pos_next;
            crc_reg        <= crc_next;
            sample_reg     <= sample_next;
            rx_crc_reg     <= rx_crc_next;
            status_rst_reg <= status_rst_next;
            latch_reg      <= latch_next;
            b2b_reg        <= b2b_next;
            ovf_reg        <= ovf_next;
        end
    end

endmodule
